// ===== rtl/core/mpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsp_pkg
// Shared types, constants and pitch table for the play-string parser.
// ----------------------------------------------------------------------------
package mpsp_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int DVD_W       = 26;
  localparam int DSR_W       = 8;

  localparam logic [DVD_W-1:0] MINUTE_US  = DVD_W'(60000000);
  localparam logic [20:0]      QUARTER_RST = 21'd500000;
  localparam logic [22:0]      LEN_RST     = 23'd500000;
  localparam logic [2:0]       OCT_RST     = 3'd3;
  localparam logic [2:0]       OCT_MAX     = 3'd6;
  localparam logic [9:0]       N_MAX       = 10'd84;
  localparam logic [9:0]       LEN_MAX     = 10'd64;
  localparam logic [9:0]       TEMPO_MIN   = 10'd32;
  localparam logic [9:0]       TEMPO_MAX   = 10'd255;

  typedef enum logic [3:0] {
    CL_OTHER, CL_NUL, CL_DIGIT, CL_NOTE, CL_O, CL_LT, CL_GT, CL_N,
    CL_L, CL_P, CL_T, CL_M, CL_S, CL_SHARP, CL_FLAT, CL_DOT
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] val;
  } char_t;

  // Top octave (octave 6) semitone frequencies.
  function automatic logic [11:0] top_hz(input logic [3:0] s);
    logic [11:0] r;
    case (s)
      4'd0:    r = 12'd2093;
      4'd1:    r = 12'd2217;
      4'd2:    r = 12'd2349;
      4'd3:    r = 12'd2489;
      4'd4:    r = 12'd2637;
      4'd5:    r = 12'd2794;
      4'd6:    r = 12'd2960;
      4'd7:    r = 12'd3136;
      4'd8:    r = 12'd3322;
      4'd9:    r = 12'd3520;
      4'd10:   r = 12'd3729;
      default: r = 12'd3951;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/music_play_string_parser.sv =====
// ----------------------------------------------------------------------------
// music_play_string_parser
// Play-string parser: characters in, tone items (frequency, sound and silence
// time) out.
// ----------------------------------------------------------------------------
// Takes one character per input beat and gives one result beat per finished
// note or rest, plus a done beat (with abort status) on the terminator byte 0;
// a note or rest that the terminator closes is carried on the done beat.
// A note's beat leaves when the character after it arrives, since a dot may
// still follow. A tempo, length or rest command also runs a divide on the
// shared one-bit-per-cycle divider. A classifying input register and a short
// character queue decouple the input from the parser; the result register
// holds the last result until it is taken, and the parser takes no new
// character from the queue while it waits.
// ----------------------------------------------------------------------------
module music_play_string_parser #(
  parameter int QUEUE_DEPTH = mpsp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  command_char,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [11:0] tone_hz,
  output logic [23:0] sound_us,
  output logic [23:0] silence_us,
  output logic        string_done,
  output logic        abort_status,
  output logic        out_valid,
  input  logic        out_stall
);

  // Front to queue
  logic            push;
  mpsp_pkg::char_t push_char;
  logic            q_full;
  // Queue to parser
  logic            pop;
  logic            q_valid;
  mpsp_pkg::char_t q_char;

  // Classify each character as it is accepted.
  mpsp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .command_char (command_char),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .push         (push),
    .push_char    (push_char),
    .q_full       (q_full)
  );

  // Hold classified characters while the parser divides.
  mpsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_char (push_char),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_char    (q_char)
  );

  // Parse, time and deliver tones.
  mpsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_char       (q_char),
    .pop          (pop),
    .tone_hz      (tone_hz),
    .sound_us     (sound_us),
    .silence_us   (silence_us),
    .string_done  (string_done),
    .abort_status (abort_status),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

// ===== rtl/core/mpsp_front.sv =====
// ----------------------------------------------------------------------------
// mpsp_front
// Input register: accept a character beat and classify it for the parser.
// ----------------------------------------------------------------------------
module mpsp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           command_char,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 push,
  output mpsp_pkg::char_t      push_char,
  input  logic                 q_full
);

  logic            f_valid;
  mpsp_pkg::char_t f_char;

  function automatic mpsp_pkg::char_t classify(input logic [7:0] c);
    mpsp_pkg::char_t r;
    logic [7:0]      u;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    r.cls = mpsp_pkg::CL_OTHER;
    r.val = 4'd0;
    if (c == 8'h00) r.cls = mpsp_pkg::CL_NUL;
    else if (c >= 8'h30 && c <= 8'h39) begin
      r.cls = mpsp_pkg::CL_DIGIT;
      r.val = 4'(c - 8'h30);
    end else if (u >= 8'h41 && u <= 8'h47) begin
      r.cls = mpsp_pkg::CL_NOTE;
      r.val = 4'(u - 8'h41);
    end else if (u == 8'h4f) r.cls = mpsp_pkg::CL_O;
    else if (u == 8'h3c) r.cls = mpsp_pkg::CL_LT;
    else if (u == 8'h3e) r.cls = mpsp_pkg::CL_GT;
    else if (u == 8'h4e) r.cls = mpsp_pkg::CL_N;
    else if (u == 8'h4c) r.cls = mpsp_pkg::CL_L;
    else if (u == 8'h50) r.cls = mpsp_pkg::CL_P;
    else if (u == 8'h54) r.cls = mpsp_pkg::CL_T;
    else if (u == 8'h4d) r.cls = mpsp_pkg::CL_M;
    else if (u == 8'h53) r.cls = mpsp_pkg::CL_S;
    else if (c == 8'h23 || c == 8'h2b) r.cls = mpsp_pkg::CL_SHARP;
    else if (c == 8'h2d) r.cls = mpsp_pkg::CL_FLAT;
    else if (c == 8'h2e) r.cls = mpsp_pkg::CL_DOT;
    return r;
  endfunction

  assign in_stall  = f_valid && q_full;
  assign push      = f_valid && !q_full;
  assign push_char = f_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      f_char <= classify(command_char);
    end
  end

endmodule

// ===== rtl/core/mpsp_queue.sv =====
// ----------------------------------------------------------------------------
// mpsp_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module mpsp_queue #(
  parameter int DEPTH = mpsp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mpsp_pkg::char_t push_char,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output mpsp_pkg::char_t q_char
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mpsp_pkg::char_t entries [DEPTH];
  logic [IW-1:0]   wr_ptr;
  logic [IW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [IW-1:0] bump(input logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_char  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) entries[wr_ptr] <= push_char;
  end

endmodule

// ===== rtl/core/mpsp_div.sv =====
// ----------------------------------------------------------------------------
// mpsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mpsp_pkg::DVD_W-1:0] dividend,
  input  logic [mpsp_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [mpsp_pkg::DVD_W-1:0] quotient
);

  localparam int NW = $clog2(mpsp_pkg::DVD_W + 1);

  logic [mpsp_pkg::DSR_W-1:0] rem;
  logic [mpsp_pkg::DSR_W-1:0] dsr;
  logic [mpsp_pkg::DVD_W-1:0] quo;
  logic [NW-1:0]              cnt;
  logic [mpsp_pkg::DSR_W:0]   trial;
  logic                       fits;

  assign trial    = {rem, quo[mpsp_pkg::DVD_W-1]};
  assign fits     = (trial >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= NW'(mpsp_pkg::DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) done <= 1'b1;
      end
    end
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? mpsp_pkg::DSR_W'(trial - {1'b0, dsr}) : trial[mpsp_pkg::DSR_W-1:0];
      quo <= {quo[mpsp_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/mpsp_back.sv =====
// ----------------------------------------------------------------------------
// mpsp_back
// Parser proper: one parse pass per cycle over the queued character while no
// divide runs, tempo, length and rest divides on the shared divider, and the
// result register.
module mpsp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  mpsp_pkg::char_t q_char,
  output logic            pop,
  output logic [11:0]     tone_hz,
  output logic [23:0]     sound_us,
  output logic [23:0]     silence_us,
  output logic            string_done,
  output logic            abort_status,
  output logic            out_valid,
  input  logic            out_stall
);

  typedef enum logic [1:0] {S_WAIT, S_PASS, S_DIV, S_END} step_t;
  typedef enum logic [3:0] {
    P_IDLE, P_ABORT, P_OCT, P_MODE, P_ACC, P_DOT, P_NUM1, P_NUM2, P_T3
  } phase_t;
  typedef enum logic [1:0] {K_N, K_L, K_P, K_T} kind_t;

  step_t          state, state_next;
  phase_t         phase, phase_next;
  kind_t          kind, kind_next;
  mpsp_pkg::cls_t cls, cls_next;
  logic [3:0]     val, val_next;
  logic [9:0]     dv, dv_next;
  logic [2:0]     oct, oct_next;
  logic [20:0]    quarter, quarter_next;
  logic [22:0]    note_len, note_len_next;
  logic [1:0]     art, art_next;
  logic [11:0]    pend_hz, pend_hz_next;
  logic [22:0]    pend_len, pend_len_next;
  logic [2:0]     letter, letter_next;
  logic           aborted, aborted_next;
  logic           again, again_next;
  logic           item_have, item_have_next;
  logic [11:0]    o_hz, o_hz_next;
  logic [23:0]    o_snd, o_snd_next;
  logic [23:0]    o_sil, o_sil_next;
  logic           o_done, o_done_next;
  logic           o_ab, o_ab_next;
  logic           o_valid, o_valid_next;

  logic                       div_start;
  logic [mpsp_pkg::DVD_W-1:0] div_dvd;
  logic [mpsp_pkg::DSR_W-1:0] div_dsr;
  logic                       div_done;
  logic [mpsp_pkg::DVD_W-1:0] div_q;

  mpsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic logic [3:0] letter_semi(input logic [2:0] l);
    logic [3:0] r;
    case (l)
      3'd1:    r = 4'd11;
      3'd2:    r = 4'd0;
      3'd3:    r = 4'd2;
      3'd4:    r = 4'd4;
      3'd5:    r = 4'd5;
      3'd6:    r = 4'd7;
      default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] pitch(input logic [4:0] semi, input logic [2:0] o);
    logic [4:0] s;
    logic [2:0] oc;
    s  = (semi >= 5'd12) ? semi - 5'd12 : semi;
    oc = (o > mpsp_pkg::OCT_MAX) ? mpsp_pkg::OCT_MAX : o;
    return mpsp_pkg::top_hz(s[3:0]) >> (mpsp_pkg::OCT_MAX - oc);
  endfunction

  function automatic logic [11:0] n_pitch(input logic [9:0] v);
    logic [6:0] n;
    logic [2:0] o;
    logic [6:0] s;
    n = 7'(v - 10'd1);
    o = '0;
    for (int k = 1; k <= 6; k++) begin
      if (n >= 7'(12 * k)) o = o + 3'd1;
    end
    s = n - 7'(o * 4'd12);
    return (v == '0) ? 12'd0 : pitch(s[4:0], o);
  endfunction

  // Temporaries of the pass logic
  logic        fin_en;
  logic [9:0]  fin_v;
  logic        rep;
  logic        emit_en;
  logic [11:0] emit_hz;
  logic [22:0] emit_len;
  logic        emit_dot;
  logic [24:0] d;
  logic [26:0] d7;
  logic [25:0] d3;
  logic [3:0]  semi;

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    kind_next      = kind;
    cls_next       = cls;
    val_next       = val;
    dv_next        = dv;
    oct_next       = oct;
    quarter_next   = quarter;
    note_len_next  = note_len;
    art_next       = art;
    pend_hz_next   = pend_hz;
    pend_len_next  = pend_len;
    letter_next    = letter;
    aborted_next   = aborted;
    again_next     = again;
    item_have_next = item_have;
    o_hz_next      = o_hz;
    o_snd_next     = o_snd;
    o_sil_next     = o_sil;
    o_done_next    = o_done;
    o_ab_next      = o_ab;
    o_valid_next   = o_valid && out_stall;
    pop            = 1'b0;
    div_start      = 1'b0;
    div_dvd        = mpsp_pkg::MINUTE_US;
    div_dsr        = '0;
    fin_en         = 1'b0;
    fin_v          = dv;
    rep            = 1'b0;
    emit_en        = 1'b0;
    emit_hz        = pend_hz;
    emit_len       = pend_len;
    emit_dot       = 1'b0;
    semi           = letter_semi(letter);

    case (state)
      S_WAIT: begin
        if (q_valid && !o_valid) begin
          pop        = 1'b1;
          cls_next   = q_char.cls;
          val_next   = q_char.val;
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        case (phase)
          P_IDLE: begin
            case (cls)
              mpsp_pkg::CL_O:  phase_next = P_OCT;
              mpsp_pkg::CL_LT: begin
                if (oct == '0) begin
                  aborted_next = 1'b1;
                  phase_next   = P_ABORT;
                end else oct_next = oct - 3'd1;
              end
              mpsp_pkg::CL_GT: begin
                if (oct >= mpsp_pkg::OCT_MAX) begin
                  aborted_next = 1'b1;
                  phase_next   = P_ABORT;
                end else oct_next = oct + 3'd1;
              end
              mpsp_pkg::CL_N: begin phase_next = P_NUM1; kind_next = K_N; end
              mpsp_pkg::CL_L: begin phase_next = P_NUM1; kind_next = K_L; end
              mpsp_pkg::CL_P: begin phase_next = P_NUM1; kind_next = K_P; end
              mpsp_pkg::CL_T: begin phase_next = P_NUM1; kind_next = K_T; end
              mpsp_pkg::CL_M: phase_next = P_MODE;
              mpsp_pkg::CL_NOTE: begin
                letter_next = val[2:0];
                phase_next  = P_ACC;
              end
              default: ;
            endcase
          end
          P_OCT: begin
            if (cls == mpsp_pkg::CL_DIGIT && val <= 4'd6) begin
              oct_next   = val[2:0];
              phase_next = P_IDLE;
            end else begin
              aborted_next = 1'b1;
              phase_next   = P_ABORT;
            end
          end
          P_MODE: begin
            phase_next = P_IDLE;
            case (cls)
              mpsp_pkg::CL_NUL: rep = 1'b1;
              mpsp_pkg::CL_N:   art_next = 2'd0;
              mpsp_pkg::CL_L:   art_next = 2'd1;
              mpsp_pkg::CL_S:   art_next = 2'd2;
              default: ;
            endcase
          end
          P_ACC: begin
            pend_len_next = note_len;
            if (cls == mpsp_pkg::CL_SHARP) begin
              if (letter == 3'd1) begin
                aborted_next = 1'b1;
                phase_next   = P_ABORT;
              end else begin
                pend_hz_next = pitch(5'(semi) + 5'd1, oct);
                phase_next   = P_DOT;
              end
            end else if (cls == mpsp_pkg::CL_FLAT) begin
              if (letter == 3'd2) begin
                aborted_next = 1'b1;
                phase_next   = P_ABORT;
              end else begin
                pend_hz_next = pitch(5'(semi) + 5'd11, oct);
                phase_next   = P_DOT;
              end
            end else begin
              pend_hz_next = pitch(5'(semi), oct);
              phase_next   = P_IDLE;
              emit_en      = 1'b1;
              emit_hz      = pend_hz_next;
              emit_len     = note_len;
              emit_dot     = (cls == mpsp_pkg::CL_DOT);
              rep          = (cls != mpsp_pkg::CL_DOT);
            end
          end
          P_DOT: begin
            phase_next = P_IDLE;
            emit_en    = 1'b1;
            emit_dot   = (cls == mpsp_pkg::CL_DOT);
            rep        = (cls != mpsp_pkg::CL_DOT);
          end
          P_NUM1: begin
            if (cls == mpsp_pkg::CL_DIGIT) begin
              dv_next    = 10'(val);
              phase_next = P_NUM2;
            end else begin
              aborted_next = 1'b1;
              phase_next   = P_ABORT;
            end
          end
          P_NUM2, P_T3: begin
            if (cls == mpsp_pkg::CL_DIGIT) begin
              if (phase == P_NUM2 && kind == K_T) begin
                dv_next    = 10'(dv * 4'd10) + 10'(val);
                phase_next = P_T3;
              end else begin
                fin_en = 1'b1;
                fin_v  = 10'(dv * 4'd10) + 10'(val);
              end
            end else begin
              fin_en = 1'b1;
              rep    = 1'b1;
            end
          end
          default: ;
        endcase

        if (fin_en) begin
          phase_next = P_IDLE;
          dv_next    = fin_v;
          case (kind)
            K_N: begin
              if (fin_v > mpsp_pkg::N_MAX) begin
                aborted_next = 1'b1;
                phase_next   = P_ABORT;
              end else begin
                pend_hz_next  = n_pitch(fin_v);
                pend_len_next = note_len;
                phase_next    = P_DOT;
              end
            end
            K_T: begin
              if (fin_v < mpsp_pkg::TEMPO_MIN || fin_v > mpsp_pkg::TEMPO_MAX) begin
                aborted_next = 1'b1;
                phase_next   = P_ABORT;
              end else begin
                div_start = 1'b1;
                div_dvd   = mpsp_pkg::MINUTE_US;
                div_dsr   = fin_v[mpsp_pkg::DSR_W-1:0];
              end
            end
            default: begin
              if (fin_v < 10'd1 || fin_v > mpsp_pkg::LEN_MAX) begin
                aborted_next = 1'b1;
                phase_next   = P_ABORT;
              end else begin
                div_start = 1'b1;
                div_dvd   = mpsp_pkg::DVD_W'({quarter, 2'b00});
                div_dsr   = fin_v[mpsp_pkg::DSR_W-1:0];
              end
            end
          endcase
        end

        again_next = rep;
        if (div_start) state_next = S_DIV;
        else if (rep)  state_next = S_PASS;
        else           state_next = S_END;
      end
      S_DIV: begin
        if (div_done) begin
          case (kind)
            K_T: begin
              quarter_next  = div_q[20:0];
              note_len_next = 23'(div_q[20:0]);
            end
            K_L: note_len_next = div_q[22:0];
            default: begin
              item_have_next = 1'b1;
              o_hz_next      = '0;
              o_snd_next     = '0;
              o_sil_next     = 24'(div_q[22:0]);
            end
          endcase
          state_next = again ? S_PASS : S_END;
        end
      end
      S_END: begin
        state_next     = S_WAIT;
        item_have_next = 1'b0;
        if (cls == mpsp_pkg::CL_NUL) begin
          // Terminator: close the string and restore the power-up settings.
          o_valid_next = 1'b1;
          o_done_next  = 1'b1;
          o_ab_next    = aborted;
          if (!item_have) begin
            o_hz_next  = '0;
            o_snd_next = '0;
            o_sil_next = '0;
          end
          phase_next    = P_IDLE;
          dv_next       = '0;
          oct_next      = mpsp_pkg::OCT_RST;
          quarter_next  = mpsp_pkg::QUARTER_RST;
          note_len_next = mpsp_pkg::LEN_RST;
          art_next      = 2'd0;
          pend_hz_next  = '0;
          pend_len_next = '0;
          letter_next   = '0;
          aborted_next  = 1'b0;
        end else begin
          o_valid_next = item_have;
          o_done_next  = 1'b0;
          o_ab_next    = 1'b0;
        end
      end
      default: state_next = S_WAIT;
    endcase

    // Articulation split of a finished note.
    d  = emit_dot ? 25'(({2'b00, emit_len} * 25'd3) >> 1) : 25'(emit_len);
    d7 = 27'(d) * 27'd7;
    d3 = 26'(d) * 26'd3;
    if (emit_en) begin
      item_have_next = 1'b1;
      o_hz_next      = emit_hz;
      case (art)
        2'd1: begin
          o_snd_next = d[23:0];
          o_sil_next = '0;
        end
        2'd2: begin
          o_snd_next = d3[25:2];
          o_sil_next = 24'(d[24:2]);
        end
        default: begin
          o_snd_next = d7[26:3];
          o_sil_next = 24'(d[24:3]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      phase     <= P_IDLE;
      dv        <= '0;
      oct       <= mpsp_pkg::OCT_RST;
      quarter   <= mpsp_pkg::QUARTER_RST;
      note_len  <= mpsp_pkg::LEN_RST;
      art       <= 2'd0;
      pend_hz   <= '0;
      pend_len  <= '0;
      letter    <= '0;
      aborted   <= 1'b0;
      again     <= 1'b0;
      item_have <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      dv        <= dv_next;
      oct       <= oct_next;
      quarter   <= quarter_next;
      note_len  <= note_len_next;
      art       <= art_next;
      pend_hz   <= pend_hz_next;
      pend_len  <= pend_len_next;
      letter    <= letter_next;
      aborted   <= aborted_next;
      again     <= again_next;
      item_have <= item_have_next;
      o_valid   <= o_valid_next;
    end
    kind   <= kind_next;
    cls    <= cls_next;
    val    <= val_next;
    o_hz   <= o_hz_next;
    o_snd  <= o_snd_next;
    o_sil  <= o_sil_next;
    o_done <= o_done_next;
    o_ab   <= o_ab_next;
  end

  assign tone_hz      = o_hz;
  assign sound_us     = o_snd;
  assign silence_us   = o_sil;
  assign string_done  = o_done;
  assign abort_status = o_ab;
  assign out_valid    = o_valid;

  a_rise_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(state) == S_END)
    else $error("result raised outside end step");
  a_abort_flagged: assert property (@(posedge clk) disable iff (rst)
    (phase == P_ABORT) |-> aborted)
    else $error("abort phase without abort flag");
  a_octave_range: assert property (@(posedge clk) disable iff (rst)
    oct <= mpsp_pkg::OCT_MAX)
    else $error("octave out of range");
  a_abort_only_done: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_ab) |-> o_done)
    else $error("abort status on a tone item");

endmodule

// ===== sim/music_play_string_checker.sv =====
// ----------------------------------------------------------------------------
// music_play_string_checker
// Watches both channels of the play-string parser, predicts each tone beat
// from the accepted characters and compares every result beat field by field.
// ----------------------------------------------------------------------------
module music_play_string_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  command_char,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] tone_hz,
  input  logic [23:0] sound_us,
  input  logic [23:0] silence_us,
  input  logic        string_done,
  input  logic        abort_status,
  input  logic        out_valid,
  input  logic        out_stall,
  output int          mismatches,
  output int          waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ABORT, PH_OCT, PH_MODE, PH_ACC, PH_DOT, PH_DIG1, PH_DIG2, PH_DIG3
  } phase_e;
  typedef enum logic [1:0] {KIND_N, KIND_L, KIND_P, KIND_T} kind_e;
  typedef enum logic [1:0] {ART_NORMAL, ART_LEGATO, ART_STACCATO} art_e;

  localparam int unsigned MINUTE_US = 60000000;

  typedef struct packed {
    logic [11:0] hz;
    logic [23:0] snd;
    logic [23:0] sil;
    logic        done;
    logic        ab;
  } tone_t;

  tone_t tones_due[$];
  int    fails = 0;

  // parser state
  phase_e      phase;
  kind_e       kind;
  art_e        art;
  int unsigned num, octave, quarter, note_len, held_hz, held_len, letter_idx;
  bit          aborted;
  // tone produced by the current character
  bit          got_tone;
  int unsigned t_hz, t_snd, t_sil;

  function automatic int unsigned octave6_hz(input int unsigned s);
    case (s % 12)
      0:  return 2093;
      1:  return 2217;
      2:  return 2349;
      3:  return 2489;
      4:  return 2637;
      5:  return 2794;
      6:  return 2960;
      7:  return 3136;
      8:  return 3322;
      9:  return 3520;
      10: return 3729;
      default: return 3951;
    endcase
  endfunction

  function automatic int unsigned letter_semitone(input int unsigned l);
    case (l)
      0: return 9;
      1: return 11;
      2: return 0;
      3: return 2;
      4: return 4;
      5: return 5;
      default: return 7;
    endcase
  endfunction

  function automatic int unsigned pitch_of(input int unsigned s, input int unsigned o);
    int unsigned oc;
    oc = (o > 6) ? 6 : o;
    return octave6_hz(s) >> (6 - oc);
  endfunction

  task automatic clear_parser();
    phase = PH_IDLE; kind = KIND_N; art = ART_NORMAL;
    num = 0; octave = 3; quarter = 500000; note_len = 500000;
    held_hz = 0; held_len = 0; letter_idx = 0; aborted = 0;
  endtask

  task automatic give_tone(input int unsigned hz, snd, sil);
    got_tone = 1; t_hz = hz; t_snd = snd; t_sil = sil;
  endtask

  task automatic go_abort();
    aborted = 1;
    phase = PH_ABORT;
  endtask

  task automatic sound_note(input bit dotted);
    int unsigned d;
    d = dotted ? held_len * 3 / 2 : held_len;
    case (art)
      ART_LEGATO:   give_tone(held_hz, d, 0);
      ART_STACCATO: give_tone(held_hz, d * 3 / 4, d / 4);
      default:      give_tone(held_hz, d * 7 / 8, d / 8);
    endcase
  endtask

  // a note closes on the next character; anything but a dot is reparsed
  task automatic close_note(input logic [7:0] c, output bit again);
    phase = PH_IDLE;
    again = (c != ".");
    sound_note(!again);
  endtask

  task automatic finish_num();
    phase = PH_IDLE;
    case (kind)
      KIND_N: begin
        if (num > 84) go_abort();
        else begin
          held_hz  = (num == 0) ? 0 : pitch_of((num - 1) % 12, (num - 1) / 12);
          held_len = note_len;
          phase    = PH_DOT;
        end
      end
      KIND_T: begin
        if (num < 32 || num > 255) go_abort();
        else begin
          quarter  = MINUTE_US / num;
          note_len = quarter;
        end
      end
      default: begin
        if (num < 1 || num > 64) go_abort();
        else if (kind == KIND_L) note_len = quarter * 4 / num;
        else give_tone(0, 0, quarter * 4 / num);
      end
    endcase
  endtask

  task automatic start_num(input kind_e k);
    kind  = k;
    phase = PH_DIG1;
  endtask

  task automatic step_char(input logic [7:0] c, output bit again);
    logic [7:0]  u;
    bit          digit;
    int unsigned semi;
    u     = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    digit = (c >= "0" && c <= "9");
    again = 0;
    case (phase)
      PH_IDLE: begin
        if (u == "O") phase = PH_OCT;
        else if (u == "<") begin
          if (octave == 0) go_abort(); else octave--;
        end else if (u == ">") begin
          if (octave >= 6) go_abort(); else octave++;
        end else if (u == "N") start_num(KIND_N);
        else if (u == "L") start_num(KIND_L);
        else if (u == "P") start_num(KIND_P);
        else if (u == "T") start_num(KIND_T);
        else if (u == "M") phase = PH_MODE;
        else if (u >= "A" && u <= "G") begin
          letter_idx = u - "A";
          phase      = PH_ACC;
        end
      end
      PH_OCT: begin
        if (c >= "0" && c <= "6") begin
          octave = c - "0";
          phase  = PH_IDLE;
        end else go_abort();
      end
      PH_MODE: begin
        phase = PH_IDLE;
        if (c == 8'd0) again = 1;
        else if (u == "N") art = ART_NORMAL;
        else if (u == "L") art = ART_LEGATO;
        else if (u == "S") art = ART_STACCATO;
      end
      PH_ACC: begin
        semi     = letter_semitone(letter_idx);
        held_len = note_len;
        if (c == "#" || c == "+") begin
          if (letter_idx == 1) go_abort();
          else begin
            held_hz = pitch_of(semi + 1, octave);
            phase   = PH_DOT;
          end
        end else if (c == "-") begin
          if (letter_idx == 2) go_abort();
          else begin
            held_hz = pitch_of(semi + 11, octave);
            phase   = PH_DOT;
          end
        end else begin
          held_hz = pitch_of(semi, octave);
          close_note(c, again);
        end
      end
      PH_DOT: close_note(c, again);
      PH_DIG1: begin
        if (digit) begin
          num   = c - "0";
          phase = PH_DIG2;
        end else go_abort();
      end
      PH_DIG2: begin
        if (digit) begin
          num = num * 10 + (c - "0");
          if (kind == KIND_T) phase = PH_DIG3;
          else finish_num();
        end else begin
          finish_num();
          again = 1;
        end
      end
      PH_DIG3: begin
        if (digit) num = num * 10 + (c - "0");
        else again = 1;
        finish_num();
      end
      default: ;
    endcase
  endtask

  task automatic parse_char(input logic [7:0] c);
    bit    again;
    tone_t t;
    got_tone = 0;
    t_hz = 0; t_snd = 0; t_sil = 0;
    for (int i = 0; i < 4; i++) begin
      step_char(c, again);
      if (!again) break;
    end
    t.done = 0;
    t.ab   = 0;
    if (c == 8'd0) begin
      t.done   = 1;
      t.ab     = aborted;
      got_tone = 1;
      clear_parser();
    end
    if (got_tone) begin
      t.hz  = t_hz[11:0];
      t.snd = t_snd[23:0];
      t.sil = t_sil[23:0];
      tones_due.push_back(t);
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want, got);
    if (want != got) begin
      fails++;
      $display("%0t %s: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    tone_t want;
    if (rst) begin
      clear_parser();
      tones_due.delete();
    end else begin
      if (in_valid && !in_stall) parse_char(command_char);
      if (out_valid && !out_stall) begin
        if (tones_due.size() == 0) begin
          fails++;
          $display("%0t unexpected beat: expected none, got hz %0d snd %0d sil %0d done %0d",
                   $time, tone_hz, sound_us, silence_us, string_done);
        end else begin
          want = tones_due.pop_front();
          check_field("tone_hz", want.hz, tone_hz);
          check_field("sound_us", want.snd, sound_us);
          check_field("silence_us", want.sil, silence_us);
          check_field("string_done", want.done, string_done);
          check_field("abort_status", want.ab, abort_status);
        end
      end
    end
    mismatches <= fails;
    waiting    <= tones_due.size();
  end

endmodule

// ===== sim/tb_music_play_string_parser.sv =====
// ----------------------------------------------------------------------------
// tb_music_play_string_parser
// Drives play strings into the parser and gives the verdict.
// ----------------------------------------------------------------------------
// A directed set of short strings hits the field extremes and every abort
// path, then random strings built from well-formed commands (with some noise
// and broken commands mixed in) run for about 1300 characters. Both sides
// idle at random; the receiver holds off once for a long stretch so the
// parser backs up, and the sender sometimes drains all results before going
// on. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_music_play_string_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_CHARS = 1300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 64;

  logic        clk;
  logic        rst;
  logic [7:0]  command_char;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] tone_hz;
  logic [23:0] sound_us;
  logic [23:0] silence_us;
  logic        string_done;
  logic        abort_status;
  logic        out_valid;
  logic        out_stall;

  int mismatches;
  int waiting;
  int chars_sent = 0;
  int beats_taken = 0;
  int idle_cycles = 0;

  music_play_string_parser uut (
    .clk, .rst, .command_char, .in_valid, .in_stall,
    .tone_hz, .sound_us, .silence_us, .string_done, .abort_status,
    .out_valid, .out_stall
  );

  music_play_string_checker chk (
    .clk, .rst, .command_char, .in_valid, .in_stall,
    .tone_hz, .sound_us, .silence_us, .string_done, .abort_status,
    .out_valid, .out_stall, .mismatches, .waiting
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: count cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Receiver: random hold-off per beat, quiet stretches with none, and one
  // long hold so the parser queue fills and the input stalls.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      gap = ((beats_taken / 60) % 4 == 3) ? 0 : $urandom_range(0, 7);
      if (beats_taken == 150) gap = LONG_HOLD;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats_taken++;
    end
  end

  // Send one character; hold valid and data until accepted.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = ((chars_sent / 150) % 4 == 2) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command_char <= c;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(8'd0);
  endtask

  // Letters go out in either case.
  task automatic send_letter(input logic [7:0] c);
    send_char($urandom_range(0, 1) ? c + 8'd32 : c);
  endtask

  task automatic send_number(input int v);
    if (v >= 100) send_char(8'h30 + 8'(v / 100));
    if (v >= 10) send_char(8'h30 + 8'((v / 10) % 10));
    send_char(8'h30 + 8'(v % 10));
  endtask

  task automatic send_maybe_dot();
    if ($urandom_range(0, 3) == 0) send_char(".");
  endtask

  // One random command, mostly well formed.
  task automatic send_command();
    int r, l, acc;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      l = $urandom_range(0, 6);
      send_letter(8'("A" + l));
      acc = $urandom_range(0, 3);
      // keep C flat and B sharp rare so strings live long
      if (((l == 2 && acc == 3) || (l == 1 && acc != 0 && acc != 3)) &&
          $urandom_range(0, 19) != 0) acc = 0;
      if (acc == 1) send_char("#");
      else if (acc == 2) send_char("+");
      else if (acc == 3) send_char("-");
      send_maybe_dot();
    end else if (r < 50) begin
      send_letter("N");
      send_number($urandom_range(0, 29) == 0 ? $urandom_range(85, 99) : $urandom_range(0, 84));
      send_maybe_dot();
    end else if (r < 57) begin
      send_letter("L");
      send_number($urandom_range(1, 64));
    end else if (r < 64) begin
      send_letter("P");
      send_number($urandom_range(1, 64));
    end else if (r < 70) begin
      send_letter("T");
      send_number($urandom_range(32, 255));
    end else if (r < 76) begin
      send_letter("O");
      send_number($urandom_range(0, 6));
    end else if (r < 82) begin
      send_char($urandom_range(0, 1) ? "<" : ">");
    end else if (r < 90) begin
      send_letter("M");
      case ($urandom_range(0, 3))
        0: send_letter("N");
        1: send_letter("L");
        2: send_letter("S");
        default: send_char(8'($urandom_range(1, 255)));
      endcase
    end else if (r < 96) begin
      send_char(8'($urandom_range(1, 255)));
    end else begin
      // broken command: out of range value or missing digit
      case ($urandom_range(0, 2))
        0: begin send_letter("L"); send_number($urandom_range(65, 99)); end
        1: begin send_letter("T"); send_number($urandom_range(0, 31)); end
        default: begin send_letter("P"); send_char("x"); end
      endcase
    end
  endtask

  initial begin
    int strings;
    rst          = 1'b1;
    in_valid     = 1'b0;
    command_char = 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, articulation, dots, and every abort path.
    send_text("t255L64o6C#b-.MSdmlN84N0.T32L1P1O0G-<");
    send_text("MxcO6>");
    send_text("c-");
    send_text("B+");
    send_text("O7");
    send_text("N85");
    send_text("L0P65");
    send_text("T31");
    send_text("T256");
    send_text("Nx");
    send_text("M");
    send_text("L4");
    send_text("E.P.");

    // Random strings.
    strings = 0;
    while (chars_sent < TARGET_CHARS) begin
      repeat ($urandom_range(1, 12)) send_command();
      // now and then end the string in the middle of a command
      if ($urandom_range(0, 9) == 0) begin
        send_letter("T");
        send_number($urandom_range(1, 99));
      end
      send_char(8'd0);
      strings++;
      if (strings % 40 == 0) begin
        // drain: hold the sender until every result has come
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== music_play_string_parser.f =====
rtl/core/mpsp_pkg.sv
rtl/core/mpsp_front.sv
rtl/core/mpsp_queue.sv
rtl/core/mpsp_div.sv
rtl/core/mpsp_back.sv
rtl/core/music_play_string_parser.sv
sim/music_play_string_checker.sv
sim/tb_music_play_string_parser.sv
